// ===== src/jan_pkg.sv =====
// shared types, constants and register codes of the joystick axis normalizer
// no dependencies; used by every other file of the block
package jan_pkg;

  // sample width of the adc reading (valid range 8..16)
  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned JAN_SB     = SAMPLE_BITS;
  localparam int unsigned JAN_PCT_W  = 8;
  localparam int unsigned JAN_MAG_W  = 7;
  localparam int unsigned JAN_DZ_W   = 7;
  localparam int unsigned JAN_SCALE  = 100;
  // dist * 100 needs seven more bits than a sample
  localparam int unsigned JAN_NUM_W  = JAN_SB + 7;
  localparam int unsigned JAN_CNT_W  = $clog2(JAN_NUM_W);
  localparam int unsigned JAN_ADDR_W = 5;
  localparam int unsigned JAN_DATA_W = 32;

  localparam logic [JAN_SB-1:0]   JAN_CENTER_RST = JAN_SB'(2048);
  localparam logic [JAN_SB-1:0]   JAN_LOW_RST    = '0;
  localparam logic [JAN_SB-1:0]   JAN_HIGH_RST   = JAN_SB'(4095);
  localparam logic [JAN_DZ_W-1:0] JAN_DZ_RST     = JAN_DZ_W'(5);
  localparam logic [JAN_SB-1:0]   JAN_MARGIN_RST = JAN_SB'(16);

  typedef enum logic [2:0] {
    REG_CALIB_VALID  = 3'd0,
    REG_CENTER_VALUE = 3'd1,
    REG_LOW_END      = 3'd2,
    REG_HIGH_END     = 3'd3,
    REG_DEADZONE     = 3'd4,
    REG_ADAPT_MARGIN = 3'd5,
    REG_ADAPT_ENABLE = 3'd6
  } jan_reg_e;

  // live configuration and tracked extremes, regs -> datapath
  typedef struct packed {
    logic                calib_valid;
    logic [JAN_SB-1:0]   center_value;
    logic [JAN_DZ_W-1:0] deadzone_percent;
    logic [JAN_SB-1:0]   adapt_margin;
    logic                adapt_enable;
    logic [JAN_SB-1:0]   tracked_min;
    logic [JAN_SB-1:0]   tracked_max;
  } jan_cfg_t;

  // widening request, datapath -> regs
  typedef struct packed {
    logic              upd_min;
    logic              upd_max;
    logic [JAN_SB-1:0] sample;
  } jan_adapt_t;

endpackage

// ===== src/jan_stream_if.sv =====
// valid/ready channel interfaces for samples in and percents out
// depends on jan_pkg
interface jan_sample_if;
  logic                      valid;
  logic                      ready;
  logic [jan_pkg::JAN_SB-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface jan_percent_if;
  logic                                valid;
  logic                                ready;
  logic signed [jan_pkg::JAN_PCT_W-1:0] axis_percent;

  modport source (output valid, output axis_percent, input ready);
  modport sink   (input valid, input axis_percent, output ready);
endinterface

// ===== src/jan_cfg_regs.sv =====
// apb register file plus the tracked min/max extremes
// depends on jan_pkg
module jan_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jan_pkg::JAN_ADDR_W-1:0] paddr,
  input  logic [jan_pkg::JAN_DATA_W-1:0] pwdata,
  output logic [jan_pkg::JAN_DATA_W-1:0] prdata,
  output logic                           pready,
  input  jan_pkg::jan_adapt_t            adapt_i,
  output jan_pkg::jan_cfg_t              cfg_o
);

  logic                            calib_q;
  logic [jan_pkg::JAN_SB-1:0]      center_q;
  logic [jan_pkg::JAN_SB-1:0]      low_q;
  logic [jan_pkg::JAN_SB-1:0]      high_q;
  logic [jan_pkg::JAN_DZ_W-1:0]    dz_q;
  logic [jan_pkg::JAN_SB-1:0]      margin_q;
  logic                            enable_q;
  logic [jan_pkg::JAN_SB-1:0]      tmin_q;
  logic [jan_pkg::JAN_SB-1:0]      tmax_q;
  logic                            wr_en;
  jan_pkg::jan_reg_e               reg_idx;
  logic [jan_pkg::JAN_SB-1:0]      wdata_s;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = jan_pkg::jan_reg_e'(paddr[4:2]);
  assign wdata_s = pwdata[jan_pkg::JAN_SB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q  <= 1'b0;
      center_q <= jan_pkg::JAN_CENTER_RST;
      low_q    <= jan_pkg::JAN_LOW_RST;
      high_q   <= jan_pkg::JAN_HIGH_RST;
      dz_q     <= jan_pkg::JAN_DZ_RST;
      margin_q <= jan_pkg::JAN_MARGIN_RST;
      enable_q <= 1'b1;
      tmin_q   <= jan_pkg::JAN_LOW_RST;
      tmax_q   <= jan_pkg::JAN_HIGH_RST;
    end else begin
      // widening only happens while busy; the user must write only while idle, the block does not enforce it
      if (adapt_i.upd_min) tmin_q <= adapt_i.sample;
      if (adapt_i.upd_max) tmax_q <= adapt_i.sample;
      if (wr_en) begin
        case (reg_idx)
          jan_pkg::REG_CALIB_VALID:  calib_q  <= pwdata[0];
          jan_pkg::REG_CENTER_VALUE: center_q <= wdata_s;
          jan_pkg::REG_LOW_END: begin
            low_q  <= wdata_s;
            tmin_q <= wdata_s;
          end
          jan_pkg::REG_HIGH_END: begin
            high_q <= wdata_s;
            tmax_q <= wdata_s;
          end
          jan_pkg::REG_DEADZONE:     dz_q     <= pwdata[jan_pkg::JAN_DZ_W-1:0];
          jan_pkg::REG_ADAPT_MARGIN: margin_q <= wdata_s;
          jan_pkg::REG_ADAPT_ENABLE: enable_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      jan_pkg::REG_CALIB_VALID:  prdata = jan_pkg::JAN_DATA_W'(calib_q);
      jan_pkg::REG_CENTER_VALUE: prdata = jan_pkg::JAN_DATA_W'(center_q);
      jan_pkg::REG_LOW_END:      prdata = jan_pkg::JAN_DATA_W'(low_q);
      jan_pkg::REG_HIGH_END:     prdata = jan_pkg::JAN_DATA_W'(high_q);
      jan_pkg::REG_DEADZONE:     prdata = jan_pkg::JAN_DATA_W'(dz_q);
      jan_pkg::REG_ADAPT_MARGIN: prdata = jan_pkg::JAN_DATA_W'(margin_q);
      jan_pkg::REG_ADAPT_ENABLE: prdata = jan_pkg::JAN_DATA_W'(enable_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.calib_valid      = calib_q;
  assign cfg_o.center_value     = center_q;
  assign cfg_o.deadzone_percent = dz_q;
  assign cfg_o.adapt_margin     = margin_q;
  assign cfg_o.adapt_enable     = enable_q;
  assign cfg_o.tracked_min      = tmin_q;
  assign cfg_o.tracked_max      = tmax_q;

endmodule

// ===== src/jan_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on jan_pkg
module jan_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jan_pkg::JAN_NUM_W-1:0] dividend_i,
  input  logic [jan_pkg::JAN_SB-1:0]    divisor_i,
  output logic                          done_o,
  output logic [jan_pkg::JAN_NUM_W-1:0] quotient_o
);

  logic [jan_pkg::JAN_NUM_W-1:0] quo_q, quo_d;
  logic [jan_pkg::JAN_SB-1:0]    rem_q, rem_d;
  logic [jan_pkg::JAN_SB-1:0]    dvs_q;
  logic [jan_pkg::JAN_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [jan_pkg::JAN_SB:0]      trial;
  logic [jan_pkg::JAN_SB:0]      diff;
  logic                          ge;
  logic                          last;

  // remainder stays below divisor, so trial fits one extra bit
  assign trial = {rem_q, quo_q[jan_pkg::JAN_NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[jan_pkg::JAN_SB-1:0] : trial[jan_pkg::JAN_SB-1:0];
  assign quo_d = {quo_q[jan_pkg::JAN_NUM_W-2:0], ge};
  assign last  = cnt_q == jan_pkg::JAN_CNT_W'(jan_pkg::JAN_NUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/joystick_axis_normalizer_unit.sv =====
// top level of the joystick axis normalizer: sequencer, mapping datapath, output register
// depends on jan_pkg, jan_stream_if, jan_cfg_regs and jan_divider
//
// Turns one raw adc sample into a signed deflection percent (-100..100) around the
// programmed center, with separate spans below and above it taken from the tracked
// extremes; a span that is not positive counts as 1. The magnitude
// |sample - center| * 100 / span is truncated, zeroed below the deadzone and clipped
// at 100. With calibration valid and adaptation on, the tracked min/max then widen to
// the sample once it passes them by more than the margin; with calibration invalid the
// result is 0 and nothing adapts. One sample is in flight at a time: sample_in.ready is
// high only when the sequencer is idle. An accepted sample passes the calc state, which
// latches the side and starts the shared restoring divider; the div state, in which the
// divider yields one quotient bit per cycle over SAMPLE_BITS + 7 bits; and the done
// state, which loads the output register and returns to idle. With calibration invalid
// the sequencer goes from idle straight to done. The result sits in an output register,
// so the next sample is accepted while it waits to be taken; a sample whose result is
// ready before the previous one was taken waits in the done state for as long as that
// stall lasts. Configuration goes through a simple apb port, register i at byte address
// 4*i; the user must write only while no transaction is pending, the block does not
// enforce it; writes to low_end/high_end also reload the tracked extremes.
module joystick_axis_normalizer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jan_sample_if.sink                     sample_in,
  jan_percent_if.source                  percent_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jan_pkg::JAN_ADDR_W-1:0] paddr,
  input  logic [jan_pkg::JAN_DATA_W-1:0] pwdata,
  output logic [jan_pkg::JAN_DATA_W-1:0] prdata,
  output logic                           pready
);

  // one-hot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } jan_state_e;

  jan_state_e                      state_q, state_d;
  jan_pkg::jan_cfg_t               cfg;
  jan_pkg::jan_adapt_t             adapt;
  logic [jan_pkg::JAN_SB-1:0]      sample_q;
  logic                            neg_q;
  logic                            zero_q;
  logic                            out_valid_q;
  logic signed [jan_pkg::JAN_PCT_W-1:0] out_pct_q;

  logic                            in_acc;
  logic                            slot_free;
  logic                            finish;
  logic                            neg;
  logic [jan_pkg::JAN_SB-1:0]      delta;
  logic [jan_pkg::JAN_SB-1:0]      span;
  logic [jan_pkg::JAN_NUM_W-1:0]   numer;
  logic                            div_start;
  logic                            div_done;
  logic [jan_pkg::JAN_NUM_W-1:0]   quot;
  logic                            below_dz;
  logic                            over_max;
  logic [jan_pkg::JAN_MAG_W-1:0]   mag;
  logic [jan_pkg::JAN_PCT_W-1:0]   mag_ext;
  logic [jan_pkg::JAN_PCT_W-1:0]   pct;
  logic [jan_pkg::JAN_SB:0]        max_lim;
  logic [jan_pkg::JAN_SB:0]        smp_plus_m;

  jan_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .adapt_i (adapt),
    .cfg_o   (cfg)
  );

  jan_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numer),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign sample_in.ready = state_q == ST_IDLE;
  assign in_acc          = sample_in.valid & sample_in.ready;
  // output register frees up in the same cycle it is taken
  assign slot_free       = ~out_valid_q | percent_out.ready;
  assign finish          = (state_q == ST_DONE) & slot_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = cfg.calib_valid ? ST_CALC : ST_DONE;
      ST_CALC: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // side select, distance and span; sample at center counts as positive side
  always_comb begin
    neg = sample_q < cfg.center_value;
    if (neg) begin
      delta = cfg.center_value - sample_q;
      span  = (cfg.center_value > cfg.tracked_min) ?
              cfg.center_value - cfg.tracked_min : jan_pkg::JAN_SB'(1);
    end else begin
      delta = sample_q - cfg.center_value;
      span  = (cfg.tracked_max > cfg.center_value) ?
              cfg.tracked_max - cfg.center_value : jan_pkg::JAN_SB'(1);
    end
  end

  // single constant multiply feeds the divider's dividend register
  assign numer     = jan_pkg::JAN_NUM_W'(delta) * jan_pkg::JAN_NUM_W'(jan_pkg::JAN_SCALE);
  assign div_start = state_q == ST_CALC;

  // deadzone on the unclipped magnitude, then clip at 100
  assign below_dz = quot < jan_pkg::JAN_NUM_W'(cfg.deadzone_percent);
  assign over_max = quot > jan_pkg::JAN_NUM_W'(jan_pkg::JAN_SCALE);
  always_comb begin
    if (zero_q || below_dz) mag = '0;
    else if (over_max)      mag = jan_pkg::JAN_MAG_W'(jan_pkg::JAN_SCALE);
    else                    mag = quot[jan_pkg::JAN_MAG_W-1:0];
  end
  assign mag_ext = {1'b0, mag};
  assign pct     = neg_q ? (~mag_ext + 1'b1) : mag_ext;

  // widening uses extremes as they were for the mapping; min test: sample + margin < min
  assign max_lim    = {1'b0, cfg.tracked_max} + {1'b0, cfg.adapt_margin};
  assign smp_plus_m = {1'b0, sample_q} + {1'b0, cfg.adapt_margin};
  assign adapt.sample  = sample_q;
  assign adapt.upd_max = finish & ~zero_q & cfg.adapt_enable &
                         ({1'b0, sample_q} > max_lim);
  assign adapt.upd_min = finish & ~zero_q & cfg.adapt_enable &
                         (smp_plus_m < {1'b0, cfg.tracked_min});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish)                 out_valid_q <= 1'b1;
      else if (percent_out.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_in.raw_sample;
      zero_q   <= ~cfg.calib_valid;
    end
    if (state_q == ST_CALC) neg_q <= neg;
    if (finish)             out_pct_q <= pct;
  end

  assign percent_out.valid        = out_valid_q;
  assign percent_out.axis_percent = out_pct_q;

endmodule

// ===== src/jan_checker.sv =====
// port-level checks of the joystick axis normalizer, bound to the top level
// depends on jan_pkg and joystick_axis_normalizer_unit
module jan_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [jan_pkg::JAN_PCT_W-1:0] out_pct_i,
  input logic                                 pready_i
);

  // result always inside the percent range
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_pct_i >= -8'sd100) && (out_pct_i <= 8'sd100))
    else $error("axis_percent out of range");

  // one sample at a time: not ready right after a transaction
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready while a sample is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pct_i))
    else $error("stalled result changed");

  // no wait states on the register port
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind joystick_axis_normalizer_unit jan_checker u_jan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_in.valid),
  .in_ready_i  (sample_in.ready),
  .out_valid_i (percent_out.valid),
  .out_ready_i (percent_out.ready),
  .out_pct_i   (percent_out.axis_percent),
  .pready_i    (pready)
);
